// ----- rtl/sle_pkg.sv -----
// sle_pkg: shared sizes, operation and status codes for the sequential list engine
// no dependencies; imported by sle_ram users and the top level
`default_nettype none
package sle_pkg;
	localparam int CAPACITY   = 128;
	localparam int DATA_WIDTH = 32;
	localparam int ADDR_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W      = $clog2(CAPACITY + 1);
	localparam int CMP_W      = ((CNT_W > 8) ? CNT_W : 8) + 1;

	localparam logic [1:0] FUNC_FIND   = 2'd0;
	localparam logic [1:0] FUNC_INSERT = 2'd1;
	localparam logic [1:0] FUNC_DELETE = 2'd2;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_FULL     = 2'd1;
	localparam logic [1:0] STAT_BADPOS   = 2'd2;
	localparam logic [1:0] STAT_NOTFOUND = 2'd3;

	typedef logic [ADDR_W-1:0]     addr_t;
	typedef logic [CNT_W-1:0]      cnt_t;
	typedef logic [DATA_WIDTH-1:0] word_t;
endpackage
`default_nettype wire

// ----- rtl/sle_ram.sv -----
// sle_ram: generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none
module sle_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule
`default_nettype wire

// ----- rtl/sequential_list_engine_top.sv -----
// sequential_list_engine_top: ordered array list with find, insert and delete
// depends on sle_pkg and sle_ram
//
// usage:
//  - request channel (req_valid/req_ready) carries func, value, position; a
//    transfer happens when both are high. req_ready is high only while the
//    sequencer is idle, so one operation is in flight at a time
//  - response channel (rsp_valid/rsp_ready) carries status, found_position and
//    entry_count, one response per request, held in an output register
//  - all work runs through one ram read port and one write port, one entry a
//    cycle: find compares entries 0..count-1 with the value until a match;
//    insert and delete move each later entry by one slot (read k, write k+-1
//    on the next cycle)
//  - a refused operation, a find on an empty list or a delete of the last
//    entry goes straight to the finish state; an append writes the value
//    first; find scans until a match or the last entry, insert and delete
//    scan the entries they move, so the scan or shift length sets the time
//  - req_ready returns in the same cycle as response valid, when the
//    sequencer leaves the finish state
//  - the next request is taken as soon as the sequencer is back to idle,
//    even while the previous response still waits for the receiver
//  - if the receiver stalls, a finished operation waits in the finish state
//    until the output register is free; nothing is dropped
//  - reset clears the entry count, sequencer state and valid flags; the ram
//    contents are not cleared, and only entries below the count are ever read
`default_nettype none
module sequential_list_engine_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_ready,
	input  wire logic [1:0]  func,
	input  wire logic [31:0] value,
	input  wire logic [7:0]  position,
	output logic             rsp_valid,
	input  wire logic        rsp_ready,
	output logic      [1:0]  status,
	output logic      [7:0]  found_position,
	output logic      [7:0]  entry_count
);
	import sle_pkg::*;

	// sequencer states
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SCAN   = 3'd1;
	localparam logic [2:0] S_DRAIN  = 3'd2;
	localparam logic [2:0] S_INS_WR = 3'd3;
	localparam logic [2:0] S_FINISH = 3'd4;

	logic [2:0] state_q;
	logic [1:0] op_q;
	word_t      val_q;
	cnt_t       count_q;
	addr_t      rk_q;        // read pointer of the scan
	addr_t      last_q;      // last index the scan reads
	addr_t      ins_idx_q;   // slot that takes the new value on insert
	logic [1:0] res_status_q;
	logic [7:0] res_fpos_q;

	// read stage: data of the read issued last cycle
	logic  rd_valid_s1;
	addr_t rd_idx_s1;

	logic  rsp_valid_q;
	logic [1:0] status_q;
	logic [7:0] found_position_q;
	logic [7:0] entry_count_q;

	// ram ports
	logic  ram_wr_en;
	addr_t ram_wr_addr;
	word_t ram_wr_data;
	logic  ram_rd_en;
	word_t ram_rd_data;

	// request checks
	logic [CMP_W-1:0] pos_w;
	logic [CMP_W-1:0] cnt_w;
	logic             is_full;
	logic             ins_bad;
	logic             del_bad;
	logic             match;
	logic             in_xfer;
	logic             out_free;

	assign pos_w   = CMP_W'(position);
	assign cnt_w   = CMP_W'(count_q);
	assign is_full = (count_q == CNT_W'(CAPACITY));
	assign ins_bad = (pos_w == '0) || (pos_w > cnt_w + CMP_W'(1));
	assign del_bad = (pos_w == '0) || (pos_w > cnt_w);
	assign match   = (ram_rd_data == val_q);
	assign in_xfer = req_valid && req_ready;
	assign out_free = !rsp_valid_q || rsp_ready;

	assign req_ready = (state_q == S_IDLE);

	// one read per scan cycle, one write per shift or final insert
	always_comb begin
		ram_rd_en   = (state_q == S_SCAN);
		ram_wr_en   = 1'b0;
		ram_wr_addr = ins_idx_q;
		ram_wr_data = val_q;
		if ((state_q == S_SCAN || state_q == S_DRAIN) && rd_valid_s1) begin
			if (op_q == FUNC_INSERT) begin
				ram_wr_en   = 1'b1;
				ram_wr_addr = rd_idx_s1 + addr_t'(1);
				ram_wr_data = ram_rd_data;
			end else if (op_q == FUNC_DELETE) begin
				ram_wr_en   = 1'b1;
				ram_wr_addr = rd_idx_s1 - addr_t'(1);
				ram_wr_data = ram_rd_data;
			end
		end else if (state_q == S_INS_WR) begin
			ram_wr_en = 1'b1;
		end
	end

	sle_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk    (clk),
		.wr_en  (ram_wr_en),
		.wr_addr(ram_wr_addr),
		.wr_data(ram_wr_data),
		.rd_en  (ram_rd_en),
		.rd_addr(rk_q),
		.rd_data(ram_rd_data)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			rd_valid_s1  <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			rd_valid_s1 <= (state_q == S_SCAN);
			rd_idx_s1   <= rk_q;

			// output register: load from the finish state, clear on transfer
			if (state_q == S_FINISH && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						op_q       <= func;
						val_q      <= DATA_WIDTH'(value);
						res_fpos_q <= '0;
						ins_idx_q  <= addr_t'(position - 8'd1);
						case (func)
							FUNC_FIND: begin
								rk_q   <= '0;
								last_q <= addr_t'(count_q - CNT_W'(1));
								if (count_q == '0) begin
									res_status_q <= STAT_NOTFOUND;
									state_q      <= S_FINISH;
								end else begin
									res_status_q <= STAT_OK;
									state_q      <= S_SCAN;
								end
							end
							FUNC_INSERT: begin
								rk_q   <= addr_t'(count_q - CNT_W'(1));
								last_q <= addr_t'(position - 8'd1);
								if (is_full) begin
									res_status_q <= STAT_FULL;
									state_q      <= S_FINISH;
								end else if (ins_bad) begin
									res_status_q <= STAT_BADPOS;
									state_q      <= S_FINISH;
								end else if (pos_w == cnt_w + CMP_W'(1)) begin
									// append: nothing to move
									res_status_q <= STAT_OK;
									state_q      <= S_INS_WR;
								end else begin
									res_status_q <= STAT_OK;
									state_q      <= S_SCAN;
								end
							end
							FUNC_DELETE: begin
								rk_q   <= addr_t'(position);
								last_q <= addr_t'(count_q - CNT_W'(1));
								if (del_bad) begin
									res_status_q <= STAT_BADPOS;
									state_q      <= S_FINISH;
								end else if (pos_w == cnt_w) begin
									// last entry: nothing to move
									res_status_q <= STAT_OK;
									count_q      <= count_q - CNT_W'(1);
									state_q      <= S_FINISH;
								end else begin
									res_status_q <= STAT_OK;
									state_q      <= S_SCAN;
								end
							end
							default: begin
								res_status_q <= STAT_BADPOS;
								state_q      <= S_FINISH;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (op_q == FUNC_INSERT) begin
						rk_q <= rk_q - addr_t'(1);
					end else begin
						rk_q <= rk_q + addr_t'(1);
					end
					if (op_q == FUNC_FIND && rd_valid_s1 && match) begin
						res_fpos_q <= 8'(CNT_W'(rd_idx_s1) + CNT_W'(1));
						state_q    <= S_FINISH;
					end else if (rk_q == last_q) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					// last read returns here
					case (op_q)
						FUNC_FIND: begin
							if (match) begin
								res_fpos_q <= 8'(CNT_W'(rd_idx_s1) + CNT_W'(1));
							end else begin
								res_status_q <= STAT_NOTFOUND;
							end
							state_q <= S_FINISH;
						end
						FUNC_INSERT: begin
							state_q <= S_INS_WR;
						end
						default: begin
							count_q <= count_q - CNT_W'(1);
							state_q <= S_FINISH;
						end
					endcase
				end
				S_INS_WR: begin
					count_q <= count_q + CNT_W'(1);
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					// wait for the output register to be free
					if (out_free) begin
						status_q         <= res_status_q;
						found_position_q <= res_fpos_q;
						entry_count_q    <= 8'(count_q);
						state_q          <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid      = rsp_valid_q;
	assign status         = status_q;
	assign found_position = found_position_q;
	assign entry_count    = entry_count_q;
endmodule
`default_nettype wire
